/* rtl/upd_pkg.sv */
// Shared constants, codes and status types for the serial packet deframer and transmit queue.
package upd_pkg;

	localparam int TXQ_DEPTH = 256;
	localparam int PKT_DEPTH = 128;

	localparam int TXQ_AW = $clog2(TXQ_DEPTH);
	localparam int TXQ_CW = $clog2(TXQ_DEPTH + 1);
	localparam int PKT_AW = $clog2(PKT_DEPTH);
	localparam int PKT_LW = $clog2(PKT_DEPTH + 1);

	localparam logic [7:0] CH_START = 8'h40;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;

	localparam logic [7:0] STAT_SAT = 8'hFF;

	typedef enum logic [2:0] {
		OP_LINE_RX     = 3'd0,
		OP_HOST_TX     = 3'd1,
		OP_TX_READY    = 3'd2,
		OP_PKT_READ    = 3'd3,
		OP_PKT_RELEASE = 3'd4
	} op_t;

	// reported deframer state codes
	localparam logic [1:0] FS_WAIT_START = 2'd0;
	localparam logic [1:0] FS_BODY       = 2'd1;
	localparam logic [1:0] FS_WAIT_LF    = 2'd2;

	typedef struct packed {
		logic       drop;
		logic       pop_ok;
		logic [7:0] count;
	} txq_stat_t;

	typedef struct packed {
		logic       ready;
		logic [7:0] length;
		logic [1:0] frame_state;
		logic       rd_hit;
	} dfr_stat_t;

endpackage

/* rtl/upd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module upd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* rtl/upd_txq.sv */
// Transmit ring queue: head/tail pointers, fill count and the queue RAM.
module upd_txq
	import upd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic       push,
	input  logic       pop,
	input  logic [7:0] data_byte,
	output txq_stat_t  stat,
	output logic [7:0] tx_rdata
);

	logic [TXQ_AW-1:0] head_q, tail_q, head_d, tail_d, head_inc, tail_inc;
	logic [TXQ_CW-1:0] fill;
	logic              full, wr_en, pop_ok;

	function automatic logic [TXQ_AW-1:0] wrap_inc(input logic [TXQ_AW-1:0] p);
		return (p == TXQ_AW'(TXQ_DEPTH - 1)) ? '0 : p + TXQ_AW'(1);
	endfunction

	always_comb begin
		head_inc = wrap_inc(head_q);
		tail_inc = wrap_inc(tail_q);
		full     = (head_inc == tail_q);
		wr_en    = accept && push && !full;
		pop_ok   = accept && pop && (head_q != tail_q);
		head_d   = wr_en  ? head_inc : head_q;
		tail_d   = pop_ok ? tail_inc : tail_q;
		if (head_d >= tail_d) begin
			fill = TXQ_CW'(head_d) - TXQ_CW'(tail_d);
		end else begin
			fill = TXQ_CW'(TXQ_DEPTH) - TXQ_CW'(tail_d) + TXQ_CW'(head_d);
		end
		stat.drop   = accept && push && full;
		stat.pop_ok = pop_ok;
		stat.count  = (32'(fill) > 255) ? STAT_SAT : 8'(fill);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
		end else begin
			head_q <= head_d;
			tail_q <= tail_d;
		end
	end

	// read at the tail on every accepted word; the data only matters for a pop
	upd_ram #(
		.WIDTH(8),
		.DEPTH(TXQ_DEPTH)
	) u_txq_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(head_q),
		.wr_data(data_byte),
		.rd_en  (accept),
		.rd_addr(tail_q),
		.rd_data(tx_rdata)
	);

endmodule

/* rtl/upd_dfr.sv */
// Packet deframer for '@' body CR LF, with body store and host read port.
module upd_dfr
	import upd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic       line_byte,
	input  logic       rel_req,
	input  logic       rd_req,
	input  logic [7:0] data_byte,
	input  logic [6:0] read_index,
	output dfr_stat_t  stat,
	output logic [7:0] pkt_rdata
);

	typedef enum logic [2:0] {
		ST_WAIT_START = 3'b001,
		ST_BODY       = 3'b010,
		ST_WAIT_LF    = 3'b100
	} dfr_state_t;

	dfr_state_t        state_q, state_d;
	logic [PKT_LW-1:0] len_q, len_d;
	logic              ready_q, ready_d, wr_en;

	always_comb begin
		state_d = state_q;
		len_d   = len_q;
		ready_d = ready_q;
		wr_en   = 1'b0;
		if (accept && line_byte) begin
			unique case (state_q)
				ST_WAIT_START: begin
					// a new packet may not start over one the host still holds
					if (data_byte == CH_START && !ready_q) begin
						state_d = ST_BODY;
						len_d   = '0;
					end
				end
				ST_BODY: begin
					if (data_byte == CH_CR) begin
						state_d = ST_WAIT_LF;
					end else if (len_q < PKT_LW'(PKT_DEPTH)) begin
						wr_en = 1'b1;
						len_d = len_q + PKT_LW'(1);
					end
				end
				ST_WAIT_LF: begin
					if (data_byte == CH_LF) begin
						state_d = ST_WAIT_START;
						ready_d = 1'b1;
					end
				end
				default: begin
					state_d = ST_WAIT_START;
				end
			endcase
		end
		if (accept && rel_req) begin
			ready_d = 1'b0;
		end
	end

	always_comb begin
		stat.ready  = ready_d;
		stat.length = (32'(len_d) > 255) ? STAT_SAT : 8'(len_d);
		stat.rd_hit = accept && rd_req && (32'(read_index) < 32'(len_q))
			&& (32'(read_index) < PKT_DEPTH);
		unique case (state_d)
			ST_WAIT_START: stat.frame_state = FS_WAIT_START;
			ST_BODY:       stat.frame_state = FS_BODY;
			ST_WAIT_LF:    stat.frame_state = FS_WAIT_LF;
			default:       stat.frame_state = FS_WAIT_START;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_WAIT_START;
			len_q   <= '0;
			ready_q <= 1'b0;
		end else begin
			state_q <= state_d;
			len_q   <= len_d;
			ready_q <= ready_d;
		end
	end

	upd_ram #(
		.WIDTH(8),
		.DEPTH(PKT_DEPTH)
	) u_pkt_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(PKT_AW'(len_q)),
		.wr_data(data_byte),
		.rd_en  (accept),
		.rd_addr(PKT_AW'(read_index)),
		.rd_data(pkt_rdata)
	);

endmodule

/* rtl/uart_packet_deframer_tx_queue_core.sv */
// Top level: command decode, transmit queue, deframer and the result register.
//
//  channel | signals                                       | role
//  --------+-----------------------------------------------+---------------------------
//  in      | in_valid, in_stall, opcode, data_byte,        | one command word per cycle
//          | read_index                                    |
//  out     | out_valid, out_stall, tx_valid, tx_byte,      | one status word per command
//          | queue_dropped, queue_count, packet_ready,     |
//          | packet_length, read_data, frame_state         |
//
// One word per cycle unless stalled; the output register takes its result at accept.
// State updates and RAM reads happen at the accept edge; the two RAMs' registered
// read data lines up with the result register.
// Reset clears queue pointers, deframer state, length and ready flag; the RAMs are
// not cleared (unwritten entries never reach the outputs).
// in_stall is high only while a result is held and out_stall is high.
module uart_packet_deframer_tx_queue_core
	import upd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] opcode,
	input  logic [7:0] data_byte,
	input  logic [6:0] read_index,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       tx_valid,
	output logic [7:0] tx_byte,
	output logic       queue_dropped,
	output logic [7:0] queue_count,
	output logic       packet_ready,
	output logic [7:0] packet_length,
	output logic [7:0] read_data,
	output logic [1:0] frame_state
);

	logic       accept;
	logic       out_valid_q;
	txq_stat_t  txq_stat, txq_s1;
	dfr_stat_t  dfr_stat, dfr_s1;
	logic [7:0] tx_rdata, pkt_rdata;

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	upd_txq u_txq (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.push     (opcode == OP_LINE_RX || opcode == OP_HOST_TX),
		.pop      (opcode == OP_TX_READY),
		.data_byte(data_byte),
		.stat     (txq_stat),
		.tx_rdata (tx_rdata)
	);

	upd_dfr u_dfr (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.line_byte (opcode == OP_LINE_RX),
		.rel_req   (opcode == OP_PKT_RELEASE),
		.rd_req    (opcode == OP_PKT_READ),
		.data_byte (data_byte),
		.read_index(read_index),
		.stat      (dfr_stat),
		.pkt_rdata (pkt_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			txq_s1 <= txq_stat;
			dfr_s1 <= dfr_stat;
		end
	end

	assign out_valid     = out_valid_q;
	assign tx_valid      = txq_s1.pop_ok;
	assign tx_byte       = txq_s1.pop_ok ? tx_rdata : 8'h00;
	assign queue_dropped = txq_s1.drop;
	assign queue_count   = txq_s1.count;
	assign packet_ready  = dfr_s1.ready;
	assign packet_length = dfr_s1.length;
	assign read_data     = dfr_s1.rd_hit ? pkt_rdata : 8'h00;
	assign frame_state   = dfr_s1.frame_state;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (32'(queue_count) <= TXQ_DEPTH - 1))
		else $error("queue count beyond capacity");

	a_pop_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && tx_valid) |-> !queue_dropped)
		else $error("pop and drop reported for one word");

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && packet_ready) |-> (frame_state == FS_WAIT_START))
		else $error("deframer left idle while a packet is pending");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (32'(packet_length) <= PKT_DEPTH))
		else $error("packet length beyond store depth");

endmodule

/* sim/tb.sv */
// Testbench for the transmit queue and packet deframer core: directed table, fill/drain, random words.
`timescale 1ns / 1ps

module tb;
	import upd_pkg::*;

	localparam int          RAND_ITEMS   = 950;
	localparam int          HOLD_CYCLES  = 64;
	localparam int          CYCLE_LIMIT  = 400000;
	localparam logic [2:0]  OP_UNUSED_LO = 3'd5;
	localparam logic [2:0]  OP_UNUSED_HI = 3'd7;

	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       queue_dropped;
		logic [7:0] queue_count;
		logic       packet_ready;
		logic [7:0] packet_length;
		logic [7:0] read_data;
		logic [1:0] frame_state;
	} status_t;

	// one stimulus word; typed rows carry their own expected status
	typedef struct packed {
		logic [2:0] op;
		logic [7:0] b;
		logic [6:0] idx;
		logic       typed;
		status_t    st;
	} word_t;

	typedef enum {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [2:0] opcode = '0;
	logic [7:0] data_byte = '0;
	logic [6:0] read_index = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       tx_valid;
	logic [7:0] tx_byte;
	logic       queue_dropped;
	logic [7:0] queue_count;
	logic       packet_ready;
	logic [7:0] packet_length;
	logic [7:0] read_data;
	logic [1:0] frame_state;

	uart_packet_deframer_tx_queue_core uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .data_byte(data_byte), .read_index(read_index),
		.out_valid(out_valid), .out_stall(out_stall),
		.tx_valid(tx_valid), .tx_byte(tx_byte), .queue_dropped(queue_dropped),
		.queue_count(queue_count), .packet_ready(packet_ready),
		.packet_length(packet_length), .read_data(read_data), .frame_state(frame_state)
	);

	always #2 clk = ~clk;

	// predictor state
	logic [7:0]  txq_mem [TXQ_DEPTH];
	int unsigned q_head = 0;
	int unsigned q_tail = 0;
	logic [1:0]  dfr_state = FS_WAIT_START;
	logic [7:0]  body_mem [PKT_DEPTH];
	int unsigned body_len = 0;
	logic        pkt_ready = 1'b0;

	status_t     status_q [$];
	status_t     predicted, observed, wanted;
	int          n_accepted = 0;
	int          n_sent = 0;
	int          errors = 0;
	int          cycles = 0;
	int          burst_left = 0;
	logic        cur_typed = 1'b0;
	status_t     cur_known = '0;
	logic        hold_pending = 1'b0;

	function automatic status_t predict_status(logic [2:0] op, logic [7:0] b, logic [6:0] idx);
		status_t     s;
		int unsigned nxt, fill;
		s = '0;
		if (op == OP_LINE_RX || op == OP_HOST_TX) begin
			nxt = (q_head + 1) % TXQ_DEPTH;
			if (nxt == q_tail) begin
				s.queue_dropped = 1'b1;
			end else begin
				txq_mem[q_head] = b;
				q_head = nxt;
			end
		end
		// line bytes reach the deframer even when the queue drops them
		if (op == OP_LINE_RX) begin
			case (dfr_state)
				FS_WAIT_START: begin
					if (b == CH_START && !pkt_ready) begin
						dfr_state = FS_BODY;
						body_len = 0;
					end
				end
				FS_BODY: begin
					if (b == CH_CR) begin
						dfr_state = FS_WAIT_LF;
					end else if (body_len < PKT_DEPTH) begin
						body_mem[body_len] = b;
						body_len++;
					end
				end
				default: begin
					if (b == CH_LF) begin
						dfr_state = FS_WAIT_START;
						pkt_ready = 1'b1;
					end
				end
			endcase
		end
		if (op == OP_TX_READY && q_tail != q_head) begin
			s.tx_valid = 1'b1;
			s.tx_byte = txq_mem[q_tail];
			q_tail = (q_tail + 1) % TXQ_DEPTH;
		end
		if (op == OP_PKT_READ && idx < body_len)
			s.read_data = body_mem[idx];
		if (op == OP_PKT_RELEASE)
			pkt_ready = 1'b0;
		fill = (q_head + TXQ_DEPTH - q_tail) % TXQ_DEPTH;
		s.queue_count = (fill > 255) ? STAT_SAT : fill[7:0];
		s.packet_ready = pkt_ready;
		s.packet_length = (body_len > 255) ? STAT_SAT : body_len[7:0];
		s.frame_state = dfr_state;
		return s;
	endfunction

	function automatic word_t row(logic [2:0] op, logic [7:0] b, logic [6:0] idx);
		return '{op: op, b: b, idx: idx, typed: 1'b0, st: '0};
	endfunction

	function automatic word_t known(logic [2:0] op, logic [7:0] b, logic [6:0] idx, status_t st);
		return '{op: op, b: b, idx: idx, typed: 1'b1, st: st};
	endfunction

	function automatic status_t stat(logic txv, logic [7:0] txb, logic drop, logic [7:0] cnt,
			logic rdy, logic [7:0] len, logic [7:0] rd, logic [1:0] fs);
		return '{tx_valid: txv, tx_byte: txb, queue_dropped: drop, queue_count: cnt,
			packet_ready: rdy, packet_length: len, read_data: rd, frame_state: fs};
	endfunction

	task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			errors++;
		end
	endtask

	// accept, predict and check at the rising edge
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("%0t: timeout", $time);
			$display("*** FAILED ***");
			$finish;
		end else begin
			if (in_valid && !in_stall) begin
				predicted = predict_status(opcode, data_byte, read_index);
				status_q.push_back(cur_typed ? cur_known : predicted);
				n_accepted++;
			end
			if (out_valid && !out_stall) begin
				observed = '{tx_valid, tx_byte, queue_dropped, queue_count, packet_ready,
					packet_length, read_data, frame_state};
				if (status_q.size() == 0) begin
					$display("%0t: status word with nothing expected, got %h", $time, observed);
					errors++;
				end else begin
					wanted = status_q.pop_front();
					check_field("tx_valid", 8'(wanted.tx_valid), 8'(observed.tx_valid));
					check_field("tx_byte", wanted.tx_byte, observed.tx_byte);
					check_field("queue_dropped", 8'(wanted.queue_dropped),
						8'(observed.queue_dropped));
					check_field("queue_count", wanted.queue_count, observed.queue_count);
					check_field("packet_ready", 8'(wanted.packet_ready),
						8'(observed.packet_ready));
					check_field("packet_length", wanted.packet_length, observed.packet_length);
					check_field("read_data", wanted.read_data, observed.read_data);
					check_field("frame_state", 8'(wanted.frame_state), 8'(observed.frame_state));
				end
			end
		end
	end

	// receiver: stall pattern changes every so often; long hold-off on request
	rx_mode_t rx_mode = RX_FREE;
	int       rx_left = 0;
	int       rx_phase = 0;

	always begin
		@(negedge clk);
		if (hold_pending) begin
			hold_pending <= 1'b0;
			out_stall <= 1'b1;
			repeat (HOLD_CYCLES - 1) @(negedge clk);
		end else begin
			if (rx_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				rx_left = $urandom_range(20, 200);
			end
			rx_left--;
			rx_phase++;
			case (rx_mode)
				RX_FREE:  out_stall <= 1'b0;
				RX_LIGHT: out_stall <= ($urandom_range(0, 99) < 30);
				RX_HEAVY: out_stall <= ($urandom_range(0, 99) < 75);
				default:  out_stall <= (rx_phase % 3 == 0);
			endcase
		end
	end

	// sender: words go out in bursts; valid stays up across back-to-back words
	task automatic send(word_t w);
		int seen, gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = $urandom_range(1, 40);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		opcode <= w.op;
		data_byte <= w.b;
		read_index <= w.idx;
		cur_typed <= w.typed;
		cur_known <= w.st;
		seen = n_accepted;
		do @(negedge clk); while (n_accepted == seen);
		n_sent++;
	endtask

	task automatic drain_wait();
		in_valid <= 1'b0;
		do @(negedge clk); while (status_q.size() != 0);
	endtask

	initial begin
		word_t       dir_tab [$];
		int          rand_base, next_hold, pick, plen, k;
		logic [7:0]  b;
		dir_tab = '{
			known(OP_TX_READY, 8'h00, 7'd0, stat(0, 0, 0, 0, 0, 0, 0, FS_WAIT_START)),
			known(OP_PKT_READ, 8'h00, 7'd127, stat(0, 0, 0, 0, 0, 0, 0, FS_WAIT_START)),
			known(OP_PKT_RELEASE, 8'h00, 7'd0, stat(0, 0, 0, 0, 0, 0, 0, FS_WAIT_START)),
			known(OP_UNUSED_LO, 8'hFF, 7'd127, stat(0, 0, 0, 0, 0, 0, 0, FS_WAIT_START)),
			known(OP_UNUSED_HI, 8'h00, 7'd0, stat(0, 0, 0, 0, 0, 0, 0, FS_WAIT_START)),
			row(OP_LINE_RX, 8'h78, 7'd0),
			row(OP_LINE_RX, CH_START, 7'd0),
			row(OP_LINE_RX, 8'hFF, 7'd0),
			row(OP_LINE_RX, 8'h00, 7'd0),
			row(OP_LINE_RX, CH_START, 7'd0),
			row(OP_LINE_RX, CH_LF, 7'd0),
			row(OP_LINE_RX, CH_CR, 7'd0),
			row(OP_LINE_RX, 8'h71, 7'd0),
			known(OP_LINE_RX, CH_LF, 7'd0, stat(0, 0, 0, 9, 1, 4, 0, FS_WAIT_START)),
			// start char ignored while a packet is pending
			known(OP_LINE_RX, CH_START, 7'd0, stat(0, 0, 0, 10, 1, 4, 0, FS_WAIT_START)),
			known(OP_PKT_READ, 8'h00, 7'd0, stat(0, 0, 0, 10, 1, 4, 8'hFF, FS_WAIT_START)),
			known(OP_PKT_READ, 8'h00, 7'd3, stat(0, 0, 0, 10, 1, 4, CH_LF, FS_WAIT_START)),
			known(OP_PKT_READ, 8'h00, 7'd4, stat(0, 0, 0, 10, 1, 4, 0, FS_WAIT_START)),
			row(OP_HOST_TX, 8'hA5, 7'd0),
			known(OP_TX_READY, 8'h00, 7'd0, stat(1, 8'h78, 0, 10, 1, 4, 0, FS_WAIT_START)),
			known(OP_PKT_RELEASE, 8'h00, 7'd0, stat(0, 0, 0, 10, 0, 4, 0, FS_WAIT_START)),
			row(OP_PKT_READ, 8'h00, 7'd1),
			row(OP_LINE_RX, CH_START, 7'd0),
			row(OP_LINE_RX, CH_CR, 7'd0),
			row(OP_LINE_RX, CH_LF, 7'd0)
		};

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		foreach (dir_tab[i])
			send(dir_tab[i]);

		// fill the queue past full, then drain it past empty
		repeat (260) send(row(OP_HOST_TX, 8'($urandom_range(0, 255)),
			7'($urandom_range(0, 127))));
		repeat (262) send(row(OP_TX_READY, 8'($urandom_range(0, 255)),
			7'($urandom_range(0, 127))));
		drain_wait();

		rand_base = n_sent;
		next_hold = n_sent;
		while (n_sent - rand_base < RAND_ITEMS) begin
			if (n_sent >= next_hold) begin
				hold_pending <= 1'b1;
				next_hold = n_sent + 500;
			end
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				// well-formed packet, mostly short bodies, now and then past PKT_DEPTH
				plen = ($urandom_range(0, 9) == 0) ? $urandom_range(120, 140) : $urandom_range(0, 16);
				send(row(OP_LINE_RX, CH_START, 7'($urandom_range(0, 127))));
				for (k = 0; k < plen; k++) begin
					b = 8'($urandom_range(0, 255));
					if (b == CH_CR)
						b = CH_START;
					send(row(OP_LINE_RX, b, 7'($urandom_range(0, 127))));
					if ($urandom_range(0, 1))
						send(row(OP_TX_READY, 8'($urandom_range(0, 255)),
							7'($urandom_range(0, 127))));
				end
				send(row(OP_LINE_RX, CH_CR, 7'($urandom_range(0, 127))));
				repeat ($urandom_range(0, 2)) begin
					b = 8'($urandom_range(0, 255));
					if (b == CH_LF)
						b = CH_CR;
					send(row(OP_LINE_RX, b, 7'($urandom_range(0, 127))));
				end
				send(row(OP_LINE_RX, CH_LF, 7'($urandom_range(0, 127))));
				repeat ($urandom_range(1, 6)) begin
					k = $urandom_range(0, 1) ? $urandom_range(0, body_len) : $urandom_range(0, 127);
					if (k > 127)
						k = 127;
					send(row(OP_PKT_READ, 8'($urandom_range(0, 255)), 7'(k)));
				end
				if ($urandom_range(0, 4) != 0)
					send(row(OP_PKT_RELEASE, 8'($urandom_range(0, 255)),
						7'($urandom_range(0, 127))));
			end else if (pick < 70) begin
				repeat ($urandom_range(1, 10))
					send(row(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
						7'($urandom_range(0, 127))));
			end else if (pick < 85) begin
				repeat ($urandom_range(1, 20))
					send(row(OP_TX_READY, 8'($urandom_range(0, 255)),
						7'($urandom_range(0, 127))));
			end else if (pick < 98) begin
				repeat ($urandom_range(1, 20))
					send(row(OP_HOST_TX, 8'($urandom_range(0, 255)),
						7'($urandom_range(0, 127))));
			end else begin
				drain_wait();
			end
		end

		drain_wait();
		repeat (8) @(negedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

/* files.f */
rtl/upd_pkg.sv
rtl/upd_ram.sv
rtl/upd_txq.sv
rtl/upd_dfr.sv
rtl/uart_packet_deframer_tx_queue_core.sv
sim/tb.sv
